FILE: src/uhld_pkg.sv
package uhld_pkg;

	localparam int MAX_FRAME = 256;
	localparam int POS_W = $clog2(MAX_FRAME + 1);
	localparam int IDX_W = 8;
	localparam int BYTE_W = 8;
	localparam int LEN_W = 2 * BYTE_W + 1;

	localparam logic [BYTE_W-1:0] SYNC_FIRST = 8'hAA;
	localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h55;
	localparam int FRAME_OVERHEAD = 5;
	localparam int HEADER_LAST = 2;
	localparam int BODY_FIRST = 3;

	typedef enum logic [0:0] {
		OP_BYTE    = 1'b0,
		OP_RELEASE = 1'b1
	} opcode_t;

	typedef enum logic [3:0] {
		PH_HUNT   = 4'b0001,
		PH_HEADER = 4'b0010,
		PH_BODY   = 4'b0100,
		PH_HOLD   = 4'b1000
	} phase_t;

	typedef struct packed {
		phase_t phase;
		logic [BYTE_W-1:0] older;
		logic [BYTE_W-1:0] newer;
		logic [POS_W-1:0] wpos;
		logic [POS_W-1:0] total;
	} state_t;

	typedef struct packed {
		logic [BYTE_W-1:0] byte_value;
		logic [IDX_W-1:0] byte_index;
		logic frame_done;
		logic length_error;
	} result_t;

endpackage

FILE: src/uhld_step.sv
module uhld_step (
	input  uhld_pkg::state_t cur,
	input  uhld_pkg::opcode_t opcode,
	input  logic [uhld_pkg::BYTE_W-1:0] rx_byte,
	output uhld_pkg::state_t nxt,
	output logic res_valid,
	output uhld_pkg::result_t res
);

	logic [uhld_pkg::LEN_W-1:0] len_sum;
	logic [uhld_pkg::POS_W-1:0] pos_inc;

	assign len_sum = {1'b0, cur.newer, rx_byte} + uhld_pkg::LEN_W'(uhld_pkg::FRAME_OVERHEAD);
	assign pos_inc = cur.wpos + uhld_pkg::POS_W'(1);

	always_comb begin
		nxt = cur;
		res_valid = 1'b0;
		res = '0;
		if (opcode == uhld_pkg::OP_RELEASE) begin
			nxt.phase = uhld_pkg::PH_HUNT;
		end else begin
			nxt.older = cur.newer;
			nxt.newer = rx_byte;
			unique case (cur.phase)
				uhld_pkg::PH_HUNT: begin
					if (rx_byte == uhld_pkg::SYNC_SECOND && cur.newer == uhld_pkg::SYNC_FIRST) begin
						nxt.phase = uhld_pkg::PH_HEADER;
						nxt.wpos = '0;
						nxt.older = '0;
						nxt.newer = '0;
					end
				end
				uhld_pkg::PH_HEADER: begin
					res_valid = 1'b1;
					res.byte_value = rx_byte;
					res.byte_index = uhld_pkg::IDX_W'(cur.wpos);
					if (cur.wpos < uhld_pkg::POS_W'(uhld_pkg::HEADER_LAST)) begin
						nxt.wpos = pos_inc;
					end else if (len_sum > uhld_pkg::LEN_W'(uhld_pkg::MAX_FRAME)) begin
						res.length_error = 1'b1;
						nxt.phase = uhld_pkg::PH_HUNT;
						nxt.wpos = '0;
					end else begin
						nxt.total = uhld_pkg::POS_W'(len_sum);
						nxt.wpos = uhld_pkg::POS_W'(uhld_pkg::BODY_FIRST);
						nxt.phase = uhld_pkg::PH_BODY;
					end
				end
				uhld_pkg::PH_BODY: begin
					res_valid = 1'b1;
					res.byte_value = rx_byte;
					res.byte_index = uhld_pkg::IDX_W'(cur.wpos);
					res.frame_done = (pos_inc >= cur.total);
					nxt.wpos = pos_inc;
					if (pos_inc >= cur.total) begin
						nxt.phase = uhld_pkg::PH_HOLD;
					end
				end
				uhld_pkg::PH_HOLD: begin
				end
				default: begin
					nxt.phase = uhld_pkg::PH_HUNT;
				end
			endcase
		end
	end

endmodule

FILE: src/uart_header_length_deframer.sv
// A request taken into the input stage gives its result on m_tvalid via the result register.
// Throughput: one request per cycle while m_tready is high (input stage and result register).
// Requests that give no result (hunt bytes, held bytes, release) leave m_tvalid low for that cycle.
// Reset: arst_n is asynchronous and active low; it returns the block to hunting for sync,
// clears the byte window, the frame position and length, and empties both stages.
module uart_header_length_deframer (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	input  logic s_tuser,         // [0] opcode
	output logic m_tvalid,
	input  logic m_tready,
	output logic [15:0] m_tdata,  // [7:0] byte_value, [15:8] byte_index
	output logic m_tlast,         // frame_done
	output logic m_tuser          // [0] length_error
);

	uhld_pkg::state_t st_q;
	uhld_pkg::state_t st_nxt;
	uhld_pkg::result_t res;
	uhld_pkg::result_t res_q;
	logic res_valid;
	logic valid_s1;
	uhld_pkg::opcode_t opcode_s1;
	logic [uhld_pkg::BYTE_W-1:0] byte_s1;
	logic m_valid_q;
	logic adv;

	assign adv = !m_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv;

	uhld_step u_step (
		.cur(st_q),
		.opcode(opcode_s1),
		.rx_byte(byte_s1),
		.nxt(st_nxt),
		.res_valid(res_valid),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			m_valid_q <= 1'b0;
			st_q.phase <= uhld_pkg::PH_HUNT;
			st_q.older <= '0;
			st_q.newer <= '0;
			st_q.wpos <= '0;
			st_q.total <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				m_valid_q <= valid_s1 && res_valid;
				if (valid_s1) begin
					st_q <= st_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			opcode_s1 <= uhld_pkg::opcode_t'(s_tuser);
			byte_s1 <= s_tdata;
		end
		if (adv) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {res_q.byte_index, res_q.byte_value};
	assign m_tlast = res_q.frame_done;
	assign m_tuser = res_q.length_error;

`ifndef SYNTHESIS
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tlast && m_tuser))
		else $error("frame_done and length_error set together");

	a_error_at_length: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[15:8] == 8'(uhld_pkg::HEADER_LAST)))
		else $error("length_error on a byte other than the last length byte");

	a_body_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == uhld_pkg::PH_BODY) |-> (st_q.wpos < st_q.total))
		else $error("body position reached frame length without holding");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(byte_s1) && $stable(st_q)))
		else $error("stalled request or state changed");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import uhld_pkg::*;

	class frame_byte_scoreboard;
		phase_t ph;
		logic [BYTE_W-1:0] older;
		logic [BYTE_W-1:0] newer;
		logic [POS_W-1:0] wpos;
		logic [POS_W-1:0] total;
		result_t expected_bytes[$];
		int fails;

		function new();
			ph = PH_HUNT;
			older = '0;
			newer = '0;
			wpos = '0;
			total = '0;
			fails = 0;
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $time, msg);
			fails++;
		endtask

		function int pending();
			return expected_bytes.size();
		endfunction

		// Advances the frame receiver by one accepted request and queues any byte it emits.
		function void note_request(opcode_t op, logic [BYTE_W-1:0] rx);
			result_t r;
			logic [LEN_W-1:0] len;
			r = '0;
			if (op == OP_RELEASE) begin
				ph = PH_HUNT;
				return;
			end
			older = newer;
			newer = rx;
			r.byte_value = rx;
			case (ph)
				PH_HUNT: begin
					if (older == SYNC_FIRST && newer == SYNC_SECOND) begin
						ph = PH_HEADER;
						wpos = '0;
						older = '0;
						newer = '0;
					end
				end
				PH_HEADER: begin
					r.byte_index = wpos[IDX_W-1:0];
					if (wpos < POS_W'(HEADER_LAST)) begin
						wpos = wpos + 1'b1;
					end else begin
						len = LEN_W'({older, newer}) + LEN_W'(FRAME_OVERHEAD);
						if (len > LEN_W'(MAX_FRAME)) begin
							r.length_error = 1'b1;
							ph = PH_HUNT;
							wpos = '0;
						end else begin
							total = len[POS_W-1:0];
							wpos = POS_W'(BODY_FIRST);
							ph = PH_BODY;
						end
					end
					expected_bytes.push_back(r);
				end
				PH_BODY: begin
					r.byte_index = wpos[IDX_W-1:0];
					wpos = wpos + 1'b1;
					r.frame_done = (wpos >= total);
					if (r.frame_done)
						ph = PH_HOLD;
					expected_bytes.push_back(r);
				end
				default: begin
				end
			endcase
		endfunction

		task check_result(result_t got);
			result_t want;
			if (expected_bytes.size() == 0) begin
				report($sformatf("result with nothing expected: value %h index %0d done %b err %b",
					got.byte_value, got.byte_index, got.frame_done, got.length_error));
				return;
			end
			want = expected_bytes.pop_front();
			if (got.byte_value !== want.byte_value)
				report($sformatf("byte_value %h, expected %h", got.byte_value, want.byte_value));
			if (got.byte_index !== want.byte_index)
				report($sformatf("byte_index %0d, expected %0d", got.byte_index, want.byte_index));
			if (got.frame_done !== want.frame_done)
				report($sformatf("frame_done %b, expected %b at index %0d",
					got.frame_done, want.frame_done, want.byte_index));
			if (got.length_error !== want.length_error)
				report($sformatf("length_error %b, expected %b at index %0d",
					got.length_error, want.length_error, want.byte_index));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic m_tlast;
	logic m_tuser;

	frame_byte_scoreboard frames = new();
	int requests_sent = 0;
	int calm_send = 0;
	int calm_recv = 0;

	uart_header_length_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("[uart_header_length_deframer] ERROR");
		$finish;
	end

	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0)
			calm = $urandom_range(20, 60);
		return $urandom_range(0, 17);
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return SYNC_FIRST;
			1: return SYNC_SECOND;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_request(opcode_t op, logic [7:0] rx);
		int gap;
		gap = draw_gap(calm_send);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= rx;
		do @(posedge clk); while (!s_tready);
		frames.note_request(op, rx);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic send_byte(logic [7:0] rx);
		send_request(OP_BYTE, rx);
	endtask

	task automatic send_release();
		send_request(OP_RELEASE, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_random_frame();
		int noise;
		int roll;
		int body;
		int cut;
		logic [15:0] plen;
		noise = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
		repeat (noise) begin
			if ($urandom_range(0, 9) == 0)
				send_release();
			else
				send_byte(pick_byte());
		end
		roll = $urandom_range(0, 99);
		if (roll < 2)
			plen = 16'(MAX_FRAME - FRAME_OVERHEAD);
		else if (roll < 14)
			plen = 16'($urandom_range(MAX_FRAME - FRAME_OVERHEAD + 1, 65535));
		else
			plen = 16'($urandom_range(0, 24));
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		send_byte(8'($urandom_range(0, 255)));
		send_byte(plen[15:8]);
		send_byte(plen[7:0]);
		if (int'(plen) + FRAME_OVERHEAD > MAX_FRAME) begin
			if ($urandom_range(0, 3) == 0)
				send_release();
			return;
		end
		body = int'(plen) + FRAME_OVERHEAD - BODY_FIRST;
		cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, body - 1) : body;
		repeat (cut) send_byte(8'($urandom_range(0, 255)));
		if (cut == body) begin
			repeat ($urandom_range(0, 4)) send_byte(pick_byte());
		end
		send_release();
	endtask

	initial begin
		result_t got;
		wait (arst_n === 1'b1);
		forever begin
			int gap;
			gap = draw_gap(calm_recv);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got.byte_value = m_tdata[7:0];
			got.byte_index = m_tdata[15:8];
			got.frame_done = m_tlast;
			got.length_error = m_tuser;
			frames.check_result(got);
			@(negedge clk);
		end
	end

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_release();
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h80);
		// A held byte still shifts the window, so sync can straddle the release.
		send_byte(SYNC_FIRST);
		send_release();
		send_byte(SYNC_SECOND);
		send_byte(8'h01);
		send_byte(8'h00);
		send_byte(8'hFC);
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		send_byte(8'h7F);
		send_byte(8'hFF);
		send_byte(SYNC_FIRST);
		// After a length error the window keeps the length bytes.
		send_byte(SYNC_SECOND);
		send_byte(8'h00);
		send_byte(8'h00);
		send_release();

		while (requests_sent < 1850)
			send_random_frame();
		s_tvalid <= 1'b0;

		while (frames.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (frames.fails == 0 && frames.pending() == 0) begin
			$display("[uart_header_length_deframer] OK");
		end else begin
			$display("[uart_header_length_deframer] ERROR");
		end
		$finish;
	end

endmodule
